>>> hw/rtl/fspx_pkg.sv
// ----------------------------------------------------------------------------
// fspx_pkg
// Shared types, constants and helpers of the form parameter sql extractor.
// ----------------------------------------------------------------------------
package fspx_pkg;

	localparam int KEY_BYTES      = 64;
	localparam int KEY_LEN_W      = $clog2(KEY_BYTES);
	localparam int MAX_TEXT_BYTES = 65536;
	localparam int TEXT_CNT_W     = $clog2(MAX_TEXT_BYTES + 2);
	localparam int CAP_W          = 17;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

	// command queue between parser and emitter
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] METHOD_GET  = 2'd0;
	localparam logic [1:0] METHOD_POST = 2'd1;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_Q     = 8'h71;
	localparam logic [7:0] CH_L     = 8'h6C;

	// "sql=" with entry 0 the first character
	localparam logic [3:0][7:0] SQL_PREFIX = {CH_EQ, CH_L, CH_Q, CH_S};

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PREFIX,
		PH_RAW,
		PH_KEY,
		PH_SKIP,
		PH_VALUE,
		PH_OK,
		PH_FAIL
	} ph_t;

	typedef enum logic [2:0] {
		KM_NONE = 3'd0,
		KM_S    = 3'd1,
		KM_SQ   = 3'd2,
		KM_SQL  = 3'd3,
		KM_Q    = 3'd4,
		KM_BAD  = 3'd7
	} km_t;

	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_HI,
		ESC_LO
	} esc_t;

	// one queue entry: up to four output bytes, then optionally the status
	typedef struct packed {
		logic [2:0]      n_bytes;
		logic [3:0][7:0] bytes;
		logic            has_status;
		logic            fail;
	} cmd_t;

	// bit 4 set means not a hex digit
	function automatic logic [4:0] hex_of(input logic [7:0] c);
		logic [4:0] r;
		begin
			r = 5'h10;
			if (c >= 8'h30 && c <= 8'h39) begin
				r = {1'b0, 4'(c - 8'h30)};
			end else if (c >= 8'h61 && c <= 8'h66) begin
				r = {1'b0, 4'(c - 8'h57)};
			end else if (c >= 8'h41 && c <= 8'h46) begin
				r = {1'b0, 4'(c - 8'h37)};
			end
			return r;
		end
	endfunction

endpackage

>>> hw/rtl/fspx_front.sv
// ----------------------------------------------------------------------------
// fspx_front
// Byte parser: tracks the request phase, decodes keys and values, checks
// output capacity and hands emit commands to the queue.
// ----------------------------------------------------------------------------
module fspx_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic [1:0]              request_method,
	input  logic [7:0]              data_byte,
	input  logic                    no_data,
	input  logic                    last_byte,
	input  logic [fspx_pkg::CAP_W-1:0] cap,
	output logic                    push,
	output fspx_pkg::cmd_t          cmd
);
	import fspx_pkg::*;

	ph_t                   ph_q, ph;
	logic [1:0]            pc_q, pc;
	logic [2:0][7:0]       hold_q, hold;
	km_t                   km_q, km;
	logic [KEY_LEN_W-1:0]  klen_q, klen;
	esc_t                  esc_q, esc;
	logic [3:0]            hi_q, hi;
	logic [CAP_W-1:0]      emc_q, emc;
	logic [TEXT_CNT_W-1:0] tc_q, tc;

	logic [3:0][7:0] pbuf;
	logic [3:0][7:0] ebuf;
	logic [2:0]      ek;
	logic [2:0]      nem;
	logic [2:0]      n;
	logic            on_sql;
	logic            on_q;
	logic [4:0]      hx;
	logic            kc_go;
	logic [7:0]      kc;
	logic            fin;
	logic            fail;

	always_comb begin
		ph    = ph_q;
		pc    = pc_q;
		hold  = hold_q;
		km    = km_q;
		klen  = klen_q;
		esc   = esc_q;
		hi    = hi_q;
		emc   = emc_q;
		tc    = tc_q;
		ek    = '0;
		ebuf  = '0;
		nem   = '0;
		kc_go = 1'b0;
		kc    = '0;
		fin   = 1'b0;
		fail  = 1'b0;
		hx    = hex_of(data_byte);
		pbuf  = '0;
		n     = '0;
		on_sql = 1'b0;
		on_q   = 1'b0;
		if (take) begin
			if (!no_data && ph == PH_IDLE) begin
				pc   = '0;
				km   = KM_NONE;
				klen = '0;
				esc  = ESC_NONE;
				hi   = '0;
				emc  = '0;
				tc   = '0;
				if (request_method == METHOD_GET) begin
					ph = PH_KEY;
				end else if (request_method == METHOD_POST) begin
					ph = PH_PREFIX;
				end else begin
					ph = PH_FAIL;
				end
			end
			// held prefix bytes followed by the current byte
			for (int i = 0; i < 3; i++) begin
				pbuf[i] = (2'(i) < pc) ? hold[i] : data_byte;
			end
			pbuf[3] = data_byte;
			n = {1'b0, pc} + 3'd1;

			if (!no_data) begin
				if (tc <= TEXT_CNT_W'(MAX_TEXT_BYTES)) begin
					tc = tc + TEXT_CNT_W'(1);
				end
				if (tc > TEXT_CNT_W'(MAX_TEXT_BYTES)) begin
					ph = PH_FAIL;
				end
				case (ph)
					PH_PREFIX: begin
						on_sql = 1'b1;
						for (int i = 0; i < 4; i++) begin
							if (3'(i) < n && pbuf[i] != SQL_PREFIX[i]) begin
								on_sql = 1'b0;
							end
						end
						on_q = (n <= 3'd2) && (pbuf[0] == CH_Q) &&
							(n < 3'd2 || pbuf[1] == CH_EQ);
						if ((on_sql && n == 3'd4) || (on_q && n == 3'd2)) begin
							ph  = PH_VALUE;
							esc = ESC_NONE;
						end else if ((on_sql || on_q) && n < 3'd4) begin
							hold[pc] = data_byte;
							pc       = n[1:0];
						end else begin
							ph   = PH_RAW;
							ek   = n;
							ebuf = pbuf;
						end
					end
					PH_RAW: begin
						ek      = 3'd1;
						ebuf[0] = data_byte;
					end
					PH_KEY: begin
						if (data_byte == CH_AMP) begin
							km   = KM_NONE;
							klen = '0;
							esc  = ESC_NONE;
							hi   = '0;
						end else if (data_byte == CH_EQ) begin
							if (esc == ESC_NONE && (km == KM_SQL || km == KM_Q)) begin
								ph = PH_VALUE;
							end else begin
								ph = PH_SKIP;
							end
						end else if (esc != ESC_NONE) begin
							if (hx[4]) begin
								km  = KM_BAD;
								esc = ESC_NONE;
							end else if (esc == ESC_HI) begin
								hi  = hx[3:0];
								esc = ESC_LO;
							end else begin
								esc   = ESC_NONE;
								kc_go = 1'b1;
								kc    = {hi, hx[3:0]};
							end
						end else if (data_byte == CH_PLUS) begin
							kc_go = 1'b1;
							kc    = CH_SPACE;
						end else if (data_byte == CH_PCT) begin
							esc = ESC_HI;
						end else begin
							kc_go = 1'b1;
							kc    = data_byte;
						end
					end
					PH_SKIP: begin
						if (data_byte == CH_AMP) begin
							ph   = PH_KEY;
							km   = KM_NONE;
							klen = '0;
							esc  = ESC_NONE;
							hi   = '0;
						end
					end
					PH_VALUE: begin
						if (data_byte == CH_AMP) begin
							ph = (esc != ESC_NONE) ? PH_FAIL : PH_OK;
						end else if (esc != ESC_NONE) begin
							if (hx[4]) begin
								ph = PH_FAIL;
							end else if (esc == ESC_HI) begin
								hi  = hx[3:0];
								esc = ESC_LO;
							end else begin
								esc     = ESC_NONE;
								ek      = 3'd1;
								ebuf[0] = {hi, hx[3:0]};
							end
						end else if (data_byte == CH_PLUS) begin
							ek      = 3'd1;
							ebuf[0] = CH_SPACE;
						end else if (data_byte == CH_PCT) begin
							esc = ESC_HI;
						end else begin
							ek      = 3'd1;
							ebuf[0] = data_byte;
						end
					end
					default: begin
					end
				endcase

				// key matcher: one decoded key character
				if (kc_go && km != KM_BAD) begin
					if (klen >= KEY_LEN_W'(KEY_BYTES - 1)) begin
						km = KM_BAD;
					end else begin
						klen = klen + KEY_LEN_W'(1);
						if (km == KM_NONE && kc == CH_S) begin
							km = KM_S;
						end else if (km == KM_NONE && kc == CH_Q) begin
							km = KM_Q;
						end else if (km == KM_S && kc == CH_Q) begin
							km = KM_SQ;
						end else if (km == KM_SQ && kc == CH_L) begin
							km = KM_SQL;
						end else begin
							km = KM_BAD;
						end
					end
				end
			end

			fin = no_data || last_byte;
			// a body cut short inside the prefix is copied raw
			if (fin && ph == PH_PREFIX) begin
				ph   = PH_RAW;
				ek   = {1'b0, pc};
				ebuf = pbuf;
			end

			// capacity: each byte needs emitted+1 below the capacity
			for (int j = 0; j < 4; j++) begin
				if (3'(j) < ek &&
					(({1'b0, emc} + (CAP_W + 1)'(j + 1)) < {1'b0, cap})) begin
					nem = nem + 3'd1;
				end
			end
			if (nem != ek) begin
				ph = PH_FAIL;
			end
			emc = emc + CAP_W'(nem);

			if (fin) begin
				case (ph)
					PH_RAW, PH_OK: fail = 1'b0;
					PH_VALUE:      fail = (esc != ESC_NONE);
					default:       fail = 1'b1;
				endcase
				if (cap == '0) begin
					fail = 1'b1;
				end
				ph   = PH_IDLE;
				pc   = '0;
				km   = KM_NONE;
				klen = '0;
				esc  = ESC_NONE;
				hi   = '0;
				emc  = '0;
				tc   = '0;
			end
		end
	end

	assign push           = take && (nem != '0 || fin);
	assign cmd.n_bytes    = nem;
	assign cmd.bytes      = ebuf;
	assign cmd.has_status = fin;
	assign cmd.fail       = fail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			pc_q   <= '0;
			km_q   <= KM_NONE;
			klen_q <= '0;
			esc_q  <= ESC_NONE;
			hi_q   <= '0;
			emc_q  <= '0;
			tc_q   <= '0;
		end else begin
			ph_q   <= ph;
			pc_q   <= pc;
			km_q   <= km;
			klen_q <= klen;
			esc_q  <= esc;
			hi_q   <= hi;
			emc_q  <= emc;
			tc_q   <= tc;
		end
	end

	always_ff @(posedge clk) begin
		hold_q <= hold;
	end

endmodule

>>> hw/rtl/fspx_fifo.sv
// ----------------------------------------------------------------------------
// fspx_fifo
// Short command queue between the parser and the result emitter.
// ----------------------------------------------------------------------------
module fspx_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fspx_pkg::cmd_t wr_data,
	input  logic           pop,
	output fspx_pkg::cmd_t rd_data,
	output logic           empty,
	output logic           full
);
	import fspx_pkg::*;

	cmd_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + Q_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - Q_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/fspx_back.sv
// ----------------------------------------------------------------------------
// fspx_back
// Result emitter: walks the head command byte by byte, then the status if it
// carries one, into a registered output stage.
// ----------------------------------------------------------------------------
module fspx_back (
	input  logic           clk,
	input  logic           arst_n,
	input  fspx_pkg::cmd_t head,
	input  logic           empty,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           result_kind,
	output logic [7:0]     out_byte,
	output logic           extract_status,
	output logic           last_result
);
	import fspx_pkg::*;

	logic [2:0] idx_q;
	logic       valid_q;
	logic       kind_q;
	logic [7:0] byte_q;
	logic       status_q;
	logic       last_q;

	logic load;
	logic fire;
	logic is_byte;
	logic done;

	assign load    = !valid_q || out_ready;
	assign fire    = load && !empty;
	assign is_byte = idx_q < head.n_bytes;
	assign done    = is_byte ? ((idx_q + 3'd1 == head.n_bytes) && !head.has_status) : 1'b1;
	assign pop     = fire && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (fire) begin
				idx_q   <= done ? 3'd0 : idx_q + 3'd1;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			kind_q   <= !is_byte;
			byte_q   <= is_byte ? head.bytes[idx_q[1:0]] : 8'h00;
			status_q <= is_byte ? 1'b0 : head.fail;
			last_q   <= !is_byte;
		end
	end

	assign out_valid      = valid_q;
	assign result_kind    = kind_q;
	assign out_byte       = byte_q;
	assign extract_status = status_q;
	assign last_result    = last_q;

endmodule

>>> hw/rtl/form_param_sql_extractor_unit.sv
// ----------------------------------------------------------------------------
// form_param_sql_extractor_unit
// Extracts the sql or q parameter from a query string or form body, url
// decoded, or copies other post bodies raw, and closes with a status item.
//
//   port group    dir   handshake            payload
//   in            in    in_valid/in_ready    request_method data_byte no_data
//                                             last_byte
//   out           out   out_valid/out_ready  result_kind out_byte
//                                             extract_status last_result
//   cfg           in    cfg_valid/cfg_ready  out_capacity
//
// The parser takes one request byte per cycle while the queue has room; the
// emitter sends one result per cycle while out_ready is high, and a single
// byte can give up to five results when a broken post prefix is flushed
// together with the status. A four-entry command queue between them lets the
// parser run ahead while the output is stalled; in_ready drops only when that
// queue is full. cfg_ready is always high. Reset gives capacity 4096 and an
// empty queue, with no clearing pass.
// ----------------------------------------------------------------------------
module form_param_sql_extractor_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  request_method,
	input  logic [7:0]                  data_byte,
	input  logic                        no_data,
	input  logic                        last_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        result_kind,
	output logic [7:0]                  out_byte,
	output logic                        extract_status,
	output logic                        last_result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [fspx_pkg::CAP_W-1:0]  out_capacity
);
	import fspx_pkg::*;

	logic [CAP_W-1:0] cap_q;
	logic             take;
	logic             push;
	logic             pop;
	logic             empty;
	logic             full;
	cmd_t             wr_cmd;
	cmd_t             head;

	assign cfg_ready = 1'b1;
	assign in_ready  = !full;
	assign take      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= out_capacity;
		end
	end

	fspx_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.request_method (request_method),
		.data_byte      (data_byte),
		.no_data        (no_data),
		.last_byte      (last_byte),
		.cap            (cap_q),
		.push           (push),
		.cmd            (wr_cmd)
	);

	fspx_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_cmd),
		.pop     (pop),
		.rd_data (head),
		.empty   (empty),
		.full    (full)
	);

	fspx_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.empty          (empty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.out_byte       (out_byte),
		.extract_status (extract_status),
		.last_result    (last_result)
	);

endmodule

>>> sim/form_param_sql_extractor_unit_tb.sv
// ----------------------------------------------------------------------------
// form_param_sql_extractor_unit_tb
// Self-checking bench for the form parameter sql extractor. Requests are
// streamed in byte by byte, a model of the parser predicts the decoded bytes
// and the closing status, and every result is compared in order. Directed
// tests cover the named corner cases and capacity limits, then random requests
// run under several capacities, idling at random on both sides save in the last.
// ----------------------------------------------------------------------------
module form_param_sql_extractor_unit_tb;
	import fspx_pkg::*;

	localparam logic [1:0] M_OTHER = 2'd2;
	localparam int SETTLE_CYCLES   = 10;
	localparam int WATCHDOG_CYCLES = 2000;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int RANDOM_ITEMS    = 90;

	typedef struct {
		bit       kind;
		bit [7:0] value;
		bit       fail;
		bit       last;
	} out_item_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          request_method;
	logic [7:0]          data_byte;
	logic                no_data;
	logic                last_byte;
	logic                out_valid;
	logic                out_ready;
	logic                result_kind;
	logic [7:0]          out_byte;
	logic                extract_status;
	logic                last_result;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CAP_W-1:0]    out_capacity;

	// parser model state
	ph_t       p_phase   = PH_IDLE;
	bit [7:0]  p_hold [3];
	int        p_hold_n  = 0;
	km_t       p_kpos    = KM_NONE;
	int        p_klen    = 0;
	esc_t      p_esc     = ESC_NONE;
	bit [3:0]  p_hinib   = 4'h0;
	int        p_emitted = 0;
	int        p_textn   = 0;
	int        p_cap     = 4096;

	out_item_t results_due[$];
	bit [7:0]  req_text[$];

	int  mismatches      = 0;
	int  items_sent      = 0;
	int  results_checked = 0;
	int  requests_sent   = 0;
	int  stall_cycles    = 0;
	int  hold_off_len    = 0;
	bit  src_idle_on     = 1'b1;
	bit  sink_idle_on    = 1'b1;

	form_param_sql_extractor_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.request_method (request_method),
		.data_byte      (data_byte),
		.no_data        (no_data),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.out_byte       (out_byte),
		.extract_status (extract_status),
		.last_result    (last_result),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.out_capacity   (out_capacity)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// parser model
	// ------------------------------------------------------------------
	function automatic int hex_digit(bit [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return -1;
	endfunction

	function automatic void clear_key();
		p_kpos  = KM_NONE;
		p_klen  = 0;
		p_esc   = ESC_NONE;
		p_hinib = 4'h0;
	endfunction

	function automatic void clear_request();
		p_hold_n  = 0;
		clear_key();
		p_emitted = 0;
		p_textn   = 0;
	endfunction

	function automatic void emit_out(bit [7:0] c);
		if (p_phase == PH_FAIL) return;
		if (p_cap == 0 || p_emitted + 1 >= p_cap) begin
			p_phase = PH_FAIL;
			return;
		end
		results_due.push_back('{1'b0, c, 1'b0, 1'b0});
		p_emitted++;
	endfunction

	function automatic void key_add(bit [7:0] c);
		if (p_kpos == KM_BAD) return;
		if (p_klen >= KEY_BYTES - 1) begin
			p_kpos = KM_BAD;
			return;
		end
		p_klen++;
		if (p_kpos == KM_NONE && c == "s") p_kpos = KM_S;
		else if (p_kpos == KM_NONE && c == "q") p_kpos = KM_Q;
		else if (p_kpos == KM_S && c == "q") p_kpos = KM_SQ;
		else if (p_kpos == KM_SQ && c == "l") p_kpos = KM_SQL;
		else p_kpos = KM_BAD;
	endfunction

	function automatic void key_in(bit [7:0] b);
		int h;
		if (b == "&") begin
			clear_key();
			return;
		end
		if (b == "=") begin
			if (p_esc == ESC_NONE && (p_kpos == KM_SQL || p_kpos == KM_Q)) begin
				p_phase = PH_VALUE;
				p_esc   = ESC_NONE;
			end else begin
				p_phase = PH_SKIP;
			end
			return;
		end
		if (p_esc != ESC_NONE) begin
			h = hex_digit(b);
			// a bad escape poisons the key but parsing of the pair goes on
			if (h < 0) begin
				p_kpos = KM_BAD;
				p_esc  = ESC_NONE;
			end else if (p_esc == ESC_HI) begin
				p_hinib = h[3:0];
				p_esc   = ESC_LO;
			end else begin
				p_esc = ESC_NONE;
				key_add({p_hinib, h[3:0]});
			end
			return;
		end
		if (b == "+") key_add(" ");
		else if (b == "%") p_esc = ESC_HI;
		else key_add(b);
	endfunction

	function automatic void value_in(bit [7:0] b);
		int h;
		if (b == "&") begin
			p_phase = (p_esc != ESC_NONE) ? PH_FAIL : PH_OK;
			return;
		end
		if (p_esc != ESC_NONE) begin
			h = hex_digit(b);
			if (h < 0) begin
				p_phase = PH_FAIL;
			end else if (p_esc == ESC_HI) begin
				p_hinib = h[3:0];
				p_esc   = ESC_LO;
			end else begin
				p_esc = ESC_NONE;
				emit_out({p_hinib, h[3:0]});
			end
			return;
		end
		if (b == "+") emit_out(" ");
		else if (b == "%") p_esc = ESC_HI;
		else emit_out(b);
	endfunction

	function automatic void prefix_in(bit [7:0] b);
		bit [7:0] sql_txt [4] = '{"s", "q", "l", "="};
		bit [7:0] seen [4];
		int       n;
		bit       on_sql;
		bit       on_q;
		n = (p_hold_n + 1 > 4) ? 4 : p_hold_n + 1;
		for (int i = 0; i < n - 1; i++) seen[i] = p_hold[i];
		seen[n-1] = b;
		on_sql = 1'b1;
		for (int i = 0; i < n; i++) if (seen[i] != sql_txt[i]) on_sql = 1'b0;
		on_q = (n <= 2) && seen[0] == "q" && (n < 2 || seen[1] == "=");
		if ((on_sql && n == 4) || (on_q && n == 2)) begin
			p_phase = PH_VALUE;
			p_esc   = ESC_NONE;
			return;
		end
		if ((on_sql || on_q) && n < 4) begin
			p_hold[n-1] = b;
			p_hold_n    = n;
			return;
		end
		// prefix broken: the held bytes and this one go out raw
		p_phase = PH_RAW;
		for (int i = 0; i < n; i++) emit_out(seen[i]);
	endfunction

	function automatic void close_request();
		bit fail;
		case (p_phase)
			PH_PREFIX: begin
				p_phase = PH_RAW;
				for (int i = 0; i < p_hold_n; i++) emit_out(p_hold[i]);
				fail = (p_phase == PH_FAIL);
			end
			PH_RAW, PH_OK: fail = 1'b0;
			PH_VALUE: fail = (p_esc != ESC_NONE);
			default: fail = 1'b1;
		endcase
		if (p_cap == 0) fail = 1'b1;
		results_due.push_back('{1'b1, 8'h00, fail, 1'b1});
		p_phase = PH_IDLE;
		clear_request();
	endfunction

	function automatic void extract_step(bit [1:0] meth, bit [7:0] b, bit nd, bit lastb);
		if (nd) begin
			close_request();
			return;
		end
		if (p_phase == PH_IDLE) begin
			clear_request();
			if (meth == METHOD_GET) p_phase = PH_KEY;
			else if (meth == METHOD_POST) p_phase = PH_PREFIX;
			else p_phase = PH_FAIL;
		end
		if (p_textn <= MAX_TEXT_BYTES) p_textn++;
		if (p_textn > MAX_TEXT_BYTES) p_phase = PH_FAIL;
		case (p_phase)
			PH_PREFIX: prefix_in(b);
			PH_RAW: emit_out(b);
			PH_KEY: key_in(b);
			PH_SKIP: begin
				if (b == "&") begin
					p_phase = PH_KEY;
					clear_key();
				end
			end
			PH_VALUE: value_in(b);
			default: ;
		endcase
		if (lastb) close_request();
	endfunction

	// ------------------------------------------------------------------
	// monitor, checker and watchdog
	// ------------------------------------------------------------------
	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : bus_monitor
		out_item_t want;
		bit        moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				p_cap = int'(out_capacity);
				moved = 1'b1;
			end
			if (in_valid && in_ready) begin
				extract_step(request_method, data_byte, no_data, last_byte);
				items_sent++;
				moved = 1'b1;
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				results_checked++;
				if (results_due.size() == 0) begin
					$display("%0t unexpected result: kind %0h byte %0h status %0h last %0h",
						$time, result_kind, out_byte, extract_status, last_result);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					check_field("result_kind", 8'(want.kind), 8'(result_kind));
					check_field("out_byte", want.value, out_byte);
					check_field("extract_status", 8'(want.fail), 8'(extract_status));
					check_field("last_result", 8'(want.last), 8'(last_result));
				end
			end
		end
		stall_cycles = moved ? 0 : stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_CYCLES) begin
			$display("%0t nothing accepted for %0d cycles", $time, WATCHDOG_CYCLES);
			$display("status: fail");
			$finish;
		end
	end

	// result sink: random stalls, or a long hold-off when one is requested
	initial begin : result_sink
		int n;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_len != 0) begin
				n = hold_off_len;
				hold_off_len = 0;
				out_ready = 1'b0;
				repeat (n) @(negedge clk);
				out_ready = 1'b1;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
				out_ready = 1'b1;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------
	task automatic send_byte(bit [1:0] meth, bit [7:0] b, bit nd, bit lastb);
		int gap;
		if (src_idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		in_valid       = 1'b1;
		request_method = meth;
		data_byte      = b;
		no_data        = nd;
		last_byte      = lastb;
		do @(posedge clk); while (!in_ready);
	endtask

	// sends req_text as one request; an empty text becomes a no_data request
	task automatic send_request(bit [1:0] meth, bit nodata_end);
		int n;
		n = req_text.size();
		requests_sent++;
		if (n == 0) begin
			send_byte(meth, 8'($urandom), 1'b1, 1'($urandom));
		end else begin
			for (int i = 0; i < n; i++) begin
				send_byte(i == 0 ? meth : 2'($urandom_range(0, 2)), req_text[i], 1'b0,
					!nodata_end && i == n - 1);
			end
			if (nodata_end) send_byte(2'($urandom_range(0, 2)), 8'($urandom), 1'b1,
				1'($urandom));
		end
		req_text.delete();
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(int cap);
		wait_drained();
		@(negedge clk);
		cfg_valid    = 1'b1;
		out_capacity = 17'(cap);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic void add_char(bit [7:0] c);
		req_text.push_back(c);
	endfunction

	function automatic void add_str(string s);
		for (int i = 0; i < s.len(); i++) req_text.push_back(s[i]);
	endfunction

	function automatic void add_rand_char();
		string pool = "selctfromwhq0129ABXYZ*(),'_";
		string hexd = "0123456789abcdefABCDEF";
		int    r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			add_char(pool[$urandom_range(0, pool.len() - 1)]);
		end else if (r < 60) begin
			add_char("+");
		end else if (r < 75) begin
			add_char("%");
			add_char(hexd[$urandom_range(0, hexd.len() - 1)]);
			add_char(hexd[$urandom_range(0, hexd.len() - 1)]);
		end else if (r < 80) begin
			add_char("%");
			add_char(8'($urandom));
		end else if (r < 85) begin
			add_char(8'h00);
		end else if (r < 88) begin
			add_char(8'hFF);
		end else if (r < 92) begin
			add_char("=");
		end else if (r < 95) begin
			add_char("&");
		end else begin
			add_char(8'($urandom));
		end
	endfunction

	function automatic void add_rand_chars(int lo, int hi);
		repeat ($urandom_range(lo, hi)) add_rand_char();
	endfunction

	function automatic void make_get_text();
		int npairs;
		npairs = $urandom_range(1, 3);
		for (int p = 0; p < npairs; p++) begin
			if (p > 0) begin
				add_char("&");
				if ($urandom_range(0, 7) == 0) add_char("&");
			end
			case ($urandom_range(0, 9))
				0, 1: add_str("sql");
				2, 3: add_str("q");
				4: add_str("s%71l");
				5: add_str("%71");
				6: add_str("sq");
				7: add_str("q+");
				8: ;
				default: add_rand_chars(1, 3);
			endcase
			if ($urandom_range(0, 9) != 0) add_char("=");
			add_rand_chars(0, 6);
		end
	endfunction

	function automatic void make_post_text();
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				add_str("sql=");
				add_rand_chars(0, 6);
			end
			3, 4: begin
				add_str("q=");
				add_rand_chars(0, 6);
			end
			5, 6: begin
				case ($urandom_range(0, 3))
					0: add_str("s");
					1: add_str("sq");
					2: add_str("sql");
					default: add_str("q");
				endcase
				add_rand_chars(0, 3);
			end
			default: add_rand_chars(1, 8);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_get_pairs();
		add_str("sql=SELECT+1%2A");
		send_request(METHOD_GET, 1'b0);
		add_str("a=1&q=x%41&sql=z");
		send_request(METHOD_GET, 1'b0);
		// empty pairs, a pair with no '=' and an empty key
		add_str("&&foo&=1&sql=ok");
		send_request(METHOD_GET, 1'b0);
	endtask

	task automatic test_key_decoding();
		add_str("s%71l=ab");
		send_request(METHOD_GET, 1'b0);
		add_str("q+=no&%71=yes");
		send_request(METHOD_GET, 1'b0);
		add_str("q%=1&sql%00=2&sql%zz=3&q=4");
		send_request(METHOD_GET, 1'b0);
		add_str("q");
		add_char(8'h00);
		add_str("=1&q=2");
		send_request(METHOD_GET, 1'b0);
		repeat (KEY_BYTES) add_char("q");
		add_str("=1&sql=2");
		send_request(METHOD_GET, 1'b0);
	endtask

	task automatic test_value_escapes();
		add_str("q=%7e%7E+%00%ff");
		add_char(8'h00);
		add_char(8'hFF);
		send_request(METHOD_GET, 1'b0);
		add_str("q=ab%4");
		send_request(METHOD_GET, 1'b0);
		add_str("q=a%g1b");
		send_request(METHOD_GET, 1'b0);
		add_str("q=a%4&b");
		send_request(METHOD_GET, 1'b0);
		add_str("q=a&sql=b");
		send_request(METHOD_GET, 1'b0);
		add_str("sql=");
		send_request(METHOD_GET, 1'b0);
	endtask

	task automatic test_post_bodies();
		add_str("sql=x+y");
		send_request(METHOD_POST, 1'b0);
		add_str("q=%41");
		send_request(METHOD_POST, 1'b0);
		add_str("hello+%41");
		send_request(METHOD_POST, 1'b0);
		// bodies that end while still on a prefix, or that break it, are copied raw
		add_str("sq");
		send_request(METHOD_POST, 1'b0);
		add_str("sql");
		send_request(METHOD_POST, 1'b1);
		add_str("qx");
		send_request(METHOD_POST, 1'b0);
		add_str("sqx=1");
		send_request(METHOD_POST, 1'b0);
	endtask

	task automatic test_failure_cases();
		add_str("q=abc");
		send_request(M_OTHER, 1'b0);
		send_request(METHOD_GET, 1'b0);
		send_request(METHOD_POST, 1'b0);
		add_str("x=1&y=2");
		send_request(METHOD_GET, 1'b0);
		add_str("sql");
		send_request(METHOD_GET, 1'b0);
		add_str("q=ab");
		send_request(METHOD_GET, 1'b1);
	endtask

	task automatic test_capacity_limits();
		write_capacity(1);
		add_str("q=a");
		send_request(METHOD_GET, 1'b0);
		add_str("sql=");
		send_request(METHOD_POST, 1'b0);
		add_str("s");
		send_request(METHOD_POST, 1'b0);
		write_capacity(3);
		add_str("q=ab");
		send_request(METHOD_GET, 1'b0);
		add_str("q=abcd");
		send_request(METHOD_GET, 1'b0);
		add_str("xyz");
		send_request(METHOD_POST, 1'b0);
		write_capacity(2);
		add_str("sq");
		send_request(METHOD_POST, 1'b0);
		write_capacity(4096);
	endtask

	task automatic test_backpressure();
		wait_drained();
		hold_off_len = HOLD_OFF_CYCLES;
		add_char("x");
		repeat (10) add_rand_char();
		send_request(METHOD_POST, 1'b0);
		add_str("q=");
		repeat (10) add_char("z");
		send_request(METHOD_GET, 1'b0);
		// sender stays quiet until every request result is back
		wait_drained();
	endtask

	task automatic test_random_requests();
		int caps [6];
		int phase_end;
		int r;
		caps = '{2, $urandom_range(3, 16), 1, 65536, $urandom_range(17, 65536), 4096};
		for (int p = 0; p < 6; p++) begin
			write_capacity(caps[p]);
			if (p == 5) begin
				src_idle_on  = 1'b0;
				sink_idle_on = 1'b0;
			end
			phase_end = items_sent + RANDOM_ITEMS / 6;
			while (items_sent < phase_end) begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					make_get_text();
					send_request(METHOD_GET, $urandom_range(0, 6) == 0);
				end else if (r < 85) begin
					make_post_text();
					send_request(METHOD_POST, $urandom_range(0, 6) == 0);
				end else if (r < 93) begin
					add_rand_chars(0, 5);
					send_request(M_OTHER, $urandom_range(0, 6) == 0);
				end else begin
					send_request(2'($urandom_range(0, 2)), 1'b0);
				end
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		request_method = METHOD_GET;
		data_byte      = 8'h00;
		no_data        = 1'b0;
		last_byte      = 1'b0;
		cfg_valid      = 1'b0;
		out_capacity   = CAP_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_get_pairs();
		test_key_decoding();
		test_value_escapes();
		test_post_bodies();
		test_failure_cases();
		test_capacity_limits();
		test_backpressure();
		test_random_requests();
		wait_drained();

		$display("covered %0d requests, %0d input items, %0d results checked",
			requests_sent, items_sent, results_checked);
		$display("get and post parsing, escapes, raw copy, failures, capacities 1 to 65536");
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/fspx_pkg.sv
hw/rtl/fspx_front.sv
hw/rtl/fspx_fifo.sv
hw/rtl/fspx_back.sv
hw/rtl/form_param_sql_extractor_unit.sv
sim/form_param_sql_extractor_unit_tb.sv
